// File: rtl/core/nts_pkg.sv
// ----------------------------------------------------------------------------
// nts_pkg
// Shared types and codes for the Newton two-equation solver.
// ----------------------------------------------------------------------------
package nts_pkg;

    // result status codes
    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_SINGULAR  = 2'd2;

    // configuration register indexes (8-byte stride)
    localparam logic [1:0] REG_DAMPING = 2'd0;
    localparam logic [1:0] REG_YAW     = 2'd1;
    localparam logic [1:0] REG_TOL     = 2'd2;
    localparam logic [1:0] REG_LIMIT   = 2'd3;

    typedef enum logic {
        AR_MUL,
        AR_DIV
    } t_ar_op;

    typedef struct packed {
        logic   start;
        t_ar_op op;
    } t_ar_req;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DRV0,
        S_DRV1,
        S_LOOP,
        S_FA,
        S_FB,
        S_FC,
        S_CHK,
        S_JA,
        S_JB,
        S_DET,
        S_NA,
        S_NB,
        S_NC,
        S_ND,
        S_NE,
        S_DA,
        S_DB,
        S_DONE
    } t_state;

endpackage

// File: rtl/core/nts_arith.sv
// ----------------------------------------------------------------------------
// nts_arith
// Shared multi-cycle fixed-point unit: saturating multiply (16-bit digits)
// and saturating restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module nts_arith #(
    parameter int W = 48,
    parameter int F = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nts_pkg::t_ar_req     i_req,
    input  logic [W-1:0]         i_a,
    input  logic [W-1:0]         i_b,
    output logic                 o_done,
    output logic [W-1:0]         o_res
);
    import nts_pkg::*;

    localparam int CH  = 16;
    localparam int NCH = (W + CH - 1) / CH;
    localparam int YP  = NCH * CH;
    localparam int DW  = W + F;
    localparam int MW  = 2 * W + F;
    localparam int CW  = $clog2(DW + 1);
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    logic          r_busy;
    t_ar_op        r_op;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic [W-1:0]  r_x;
    logic [YP-1:0] r_y;
    logic [2*W-1:0] r_acc;
    logic [W-1:0]  r_md;
    logic [W:0]    r_rem;
    logic [DW-1:0] r_n;
    logic          r_done;
    logic [W-1:0]  r_res;

    logic [W-1:0]    mag_a, mag_b;
    logic [W+CH-1:0] pp;
    logic [W:0]      rem_sh;
    logic            ge;
    logic [MW-1:0]   fin_mag;
    logic [W-1:0]    fin_val;

    always_comb begin
        mag_a   = i_a[W-1] ? (W'(0) - i_a) : i_a;
        mag_b   = i_b[W-1] ? (W'(0) - i_b) : i_b;
        pp      = r_x * r_y[YP-1 -: CH];
        rem_sh  = {r_rem[W-1:0], r_n[DW-1]};
        ge      = rem_sh >= {1'b0, r_md};
        if (r_op == AR_MUL) begin
            fin_mag = {{F{1'b0}}, r_acc} >> F;
        end else begin
            fin_mag = {{(MW-DW){1'b0}}, r_n};
        end
        if (fin_mag > {{(MW-W){1'b0}}, VMAX}) begin
            fin_val = r_neg ? VMIN : VMAX;
        end else begin
            fin_val = r_neg ? (W'(0) - fin_mag[W-1:0]) : fin_mag[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_neg  <= i_a[W-1] ^ i_b[W-1];
                r_x    <= mag_a;
                r_y    <= {mag_b, {(YP-W){1'b0}}};
                r_acc  <= '0;
                r_md   <= mag_b;
                r_rem  <= '0;
                r_n    <= {mag_a, {F{1'b0}}};
                r_cnt  <= (i_req.op == AR_MUL) ? CW'(NCH) : CW'(DW);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_op == AR_MUL) begin
                        r_acc <= (r_acc << CH) + {{(W-CH){1'b0}}, pp};
                        r_y   <= r_y << CH;
                    end else begin
                        r_rem <= ge ? (rem_sh - {1'b0, r_md}) : rem_sh;
                        r_n   <= {r_n[DW-2:0], ge};
                    end
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= fin_val;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: rtl/core/newton_two_equation_solver_top.sv
// ----------------------------------------------------------------------------
// newton_two_equation_solver_top
// Newton-Raphson solver for two fixed nonlinear equations in saturating
// signed fixed point, with an APB-style register port.
// ----------------------------------------------------------------------------
// Sequence: a setup phase computes the drive term, then each iteration runs
//   its multiplies and divides in turn on the single shared multiply/divide
//   unit; total time scales with the iterations run, up to iteration_limit.
// Throughput: one transaction at a time; busy stays high until the result.
// The result is shown for one cycle on o_valid; the receiver cannot stall.
// Reset (synchronous, active low) idles the sequencer and loads the
//   register defaults: damping 1.0, yaw 5.0, tolerance ~1e-6, limit 1000.
module newton_two_equation_solver_top #(
    parameter int WORD_BITS     = 48,
    parameter int FRACTION_BITS = 32,
    parameter int COUNT_BITS    = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // APB-style register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    // command side
    input  logic                  start,
    output logic                  busy,
    input  logic [WORD_BITS-1:0]  i_q1_start,
    input  logic [WORD_BITS-1:0]  i_q2_start,
    input  logic [WORD_BITS-1:0]  i_vertical_speed,
    input  logic [WORD_BITS-1:0]  i_rate_r,
    input  logic [WORD_BITS-1:0]  i_accel_z,
    input  logic [WORD_BITS-1:0]  i_torque_z,
    // result side
    output logic                  o_valid,
    output logic [WORD_BITS-1:0]  o_q1_result,
    output logic [WORD_BITS-1:0]  o_q2_result,
    output logic [1:0]            o_status,
    output logic [COUNT_BITS-1:0] o_iterations_used
);
    import nts_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int CB = COUNT_BITS;
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    // register defaults, derived from the fraction and count widths
    localparam longint unsigned ONE_FX   = 64'd1 << F;
    localparam longint unsigned TOL_FX   = (ONE_FX + 64'd500000) / 64'd1000000;
    localparam longint unsigned LIM_MAX  = (64'd1 << CB) - 64'd1;
    localparam longint unsigned LIM_DEF  = (LIM_MAX < 64'd1000) ? LIM_MAX : 64'd1000;
    localparam logic [W-2:0]  DAMP_RST = (W-1)'(ONE_FX);
    localparam logic [W-2:0]  YAW_RST  = (W-1)'(ONE_FX * 64'd5);
    localparam logic [W-2:0]  TOL_RST  = (W-1)'(TOL_FX);
    localparam logic [CB-1:0] LIM_RST  = CB'(LIM_DEF);

    // saturating add/sub/negate and a magnitude helper on W-bit two's complement
    function automatic logic [W-1:0] sat1(input logic [W:0] s);
        if (s[W] != s[W-1]) begin
            return s[W] ? VMIN : VMAX;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
        return sat1({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic logic [W-1:0] ssub(input logic [W-1:0] a, input logic [W-1:0] b);
        return sat1({a[W-1], a} - {b[W-1], b});
    endfunction

    function automatic logic [W-1:0] sneg(input logic [W-1:0] a);
        return (a == VMIN) ? VMAX : (W'(0) - a);
    endfunction

    function automatic logic [W-1:0] smag(input logic [W-1:0] a);
        return a[W-1] ? (W'(0) - a) : a;
    endfunction

    // configuration registers
    logic [W-2:0]  r_damp, r_yaw, r_tol;
    logic [CB-1:0] r_limit;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damp  <= DAMP_RST;
            r_yaw   <= YAW_RST;
            r_tol   <= TOL_RST;
            r_limit <= LIM_RST;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_DAMPING: r_damp  <= pwdata[W-2:0];
                REG_YAW:     r_yaw   <= pwdata[W-2:0];
                REG_TOL:     r_tol   <= pwdata[W-2:0];
                REG_LIMIT:   r_limit <= pwdata[CB-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_DAMPING: prdata = {{(65-W){1'b0}}, r_damp};
            REG_YAW:     prdata = {{(65-W){1'b0}}, r_yaw};
            REG_TOL:     prdata = {{(65-W){1'b0}}, r_tol};
            REG_LIMIT:   prdata = {{(64-CB){1'b0}}, r_limit};
            default:     prdata = '0;
        endcase
    end

    // solver state
    t_state        r_state, n_state;
    logic          r_wait;
    logic [W-1:0]  r_q1s, r_q2s, r_vz, r_rr, r_az, r_tz;
    logic [W-1:0]  r_q1, r_q2, r_d, r_drive;
    logic [W-1:0]  r_t1, r_t2, r_t3, r_t4;
    logic [W-1:0]  r_f0, r_f1, r_j00, r_j01, r_det, r_n0, r_n1;
    logic [CB-1:0] r_iter;
    logic [1:0]    r_status;

    logic [W-1:0]  cp, j11;
    assign cp  = {1'b0, r_yaw};
    assign j11 = W'(0) - cp;

    // shared arithmetic unit
    t_ar_req       ar_req;
    logic [W-1:0]  ar_a, ar_b, ar_res;
    logic          ar_done, op_state;

    nts_arith #(.W(W), .F(F)) u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ar_req),
        .i_a     (ar_a),
        .i_b     (ar_b),
        .o_done  (ar_done),
        .o_res   (ar_res)
    );

    // operand selection per step
    always_comb begin
        op_state  = 1'b1;
        ar_req.op = AR_MUL;
        ar_a      = r_q1;
        ar_b      = r_q2;
        unique case (r_state)
            S_DRV0: begin ar_a = {1'b0, r_damp}; ar_b = r_vz; end
            S_DRV1: begin ar_a = r_t1;  ar_b = r_rr;  end
            S_FA:   begin ar_a = r_q1;  ar_b = r_q2;  end
            S_FB:   begin ar_a = r_d;   ar_b = r_d;   end
            S_FC:   begin ar_a = cp;    ar_b = r_d;   end
            S_JA:   begin ar_a = r_j00; ar_b = j11;   end
            S_JB:   begin ar_a = r_j01; ar_b = cp;    end
            S_NA:   begin ar_a = j11;   ar_b = r_f0;  end
            S_NB:   begin ar_a = r_j01; ar_b = r_f1;  end
            S_NC:   begin ar_a = r_j00; ar_b = r_f1;  end
            S_ND:   begin ar_a = cp;    ar_b = r_f0;  end
            S_DA:   begin ar_a = r_n0;  ar_b = r_det; ar_req.op = AR_DIV; end
            S_DB:   begin ar_a = r_n1;  ar_b = r_det; ar_req.op = AR_DIV; end
            default: op_state = 1'b0;
        endcase
        ar_req.start = op_state & ~r_wait;
    end

    // check-step values: residuals and Jacobian entries
    logic [W-1:0] g_raw, g_val, f0_val, f1_val, dd, j00_raw, j01_raw;
    logic         conv;
    always_comb begin
        g_raw   = ssub(r_t1, r_t2);
        g_val   = r_az[W-1] ? sneg(g_raw) : g_raw;
        f0_val  = ssub(ssub(g_val, r_drive), r_az);
        f1_val  = ssub(r_t3, r_tz);
        dd      = sadd(r_d, r_d);
        j00_raw = ssub(r_q2, dd);
        j01_raw = sadd(r_q1, dd);
        conv    = (smag(f0_val) < {1'b0, r_tol}) && (smag(f1_val) < {1'b0, r_tol});
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (start) n_state = S_DRV0;
            S_DRV0: if (ar_done) n_state = S_DRV1;
            S_DRV1: if (ar_done) n_state = S_LOOP;
            S_LOOP: n_state = (r_iter < r_limit) ? S_FA : S_DONE;
            S_FA:   if (ar_done) n_state = S_FB;
            S_FB:   if (ar_done) n_state = S_FC;
            S_FC:   if (ar_done) n_state = S_CHK;
            S_CHK:  n_state = conv ? S_DONE : S_JA;
            S_JA:   if (ar_done) n_state = S_JB;
            S_JB:   if (ar_done) n_state = S_DET;
            S_DET:  n_state = (ssub(r_t1, r_t2) == '0) ? S_DONE : S_NA;
            S_NA:   if (ar_done) n_state = S_NB;
            S_NB:   if (ar_done) n_state = S_NC;
            S_NC:   if (ar_done) n_state = S_ND;
            S_ND:   if (ar_done) n_state = S_NE;
            S_NE:   n_state = S_DA;
            S_DA:   if (ar_done) n_state = S_DB;
            S_DB:   if (ar_done) n_state = S_LOOP;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (op_state) begin
                r_wait <= ar_done ? 1'b0 : 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_q1s    <= i_q1_start;
                r_q2s    <= i_q2_start;
                r_q1     <= i_q1_start;
                r_q2     <= i_q2_start;
                r_vz     <= i_vertical_speed;
                r_rr     <= i_rate_r;
                r_az     <= i_accel_z;
                r_tz     <= i_torque_z;
                r_iter   <= '0;
                r_status <= ST_LIMIT;
            end
            S_DRV0: if (ar_done) r_t1 <= ar_res;
            S_DRV1: if (ar_done) r_drive <= ar_res;
            S_LOOP: r_d <= ssub(r_q1, r_q2);
            S_FA:   if (ar_done) r_t1 <= ar_res;
            S_FB:   if (ar_done) r_t2 <= ar_res;
            S_FC:   if (ar_done) r_t3 <= ar_res;
            S_CHK: begin
                r_f0  <= f0_val;
                r_f1  <= f1_val;
                r_j00 <= r_az[W-1] ? sneg(j00_raw) : j00_raw;
                r_j01 <= r_az[W-1] ? sneg(j01_raw) : j01_raw;
                if (conv) r_status <= ST_CONVERGED;
            end
            S_JA:   if (ar_done) r_t1 <= ar_res;
            S_JB:   if (ar_done) r_t2 <= ar_res;
            S_DET: begin
                r_det <= ssub(r_t1, r_t2);
                if (ssub(r_t1, r_t2) == '0) r_status <= ST_SINGULAR;
            end
            S_NA:   if (ar_done) r_t1 <= ar_res;
            S_NB:   if (ar_done) r_t2 <= ar_res;
            S_NC:   if (ar_done) r_t3 <= ar_res;
            S_ND:   if (ar_done) r_t4 <= ar_res;
            S_NE: begin
                r_n0 <= ssub(r_t1, r_t2);
                r_n1 <= ssub(r_t3, r_t4);
            end
            S_DA:   if (ar_done) r_q1 <= sadd(r_q1, sneg(ar_res));
            S_DB: begin
                if (ar_done) begin
                    r_q2   <= sadd(r_q2, sneg(ar_res));
                    r_iter <= r_iter + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // result transaction; failures report the starting guess
    assign busy              = (r_state != S_IDLE);
    assign o_valid           = (r_state == S_DONE);
    assign o_q1_result       = (r_status == ST_CONVERGED) ? r_q1 : r_q1s;
    assign o_q2_result       = (r_status == ST_CONVERGED) ? r_q2 : r_q2s;
    assign o_status          = r_status;
    assign o_iterations_used = r_iter;

endmodule
